// ===== src/nbd_pkg.sv =====
`default_nettype none
package nbd_pkg;

  localparam int FIELD_N = 63;
  localparam logic [6:0] FIELD_POLY = 7'h61;
  localparam int WORD_W = 63;

  typedef logic [5:0] gf_t;

  typedef struct packed {
    logic load;
    logic syn_step;
    logic bm_init;
    logic bm_mul;
    logic bm_red;
    logic bm_upd;
    logic ch_init;
    logic ch_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic l_over;
  } stat_t;

  function automatic gf_t gf_xtime(input gf_t a);
    gf_t r;
    r = {a[4:0], 1'b0} ^ (a[5] ? FIELD_POLY[5:0] : 6'd0);
    return r;
  endfunction

  function automatic gf_t gf_mul(input gf_t a, input gf_t b);
    gf_t r;
    gf_t p;
    r = '0;
    p = a;
    for (int i = 0; i < 6; i++) begin
      if (b[i]) r = r ^ p;
      p = gf_xtime(p);
    end
    return r;
  endfunction

  // alpha^e, used with constant exponents only
  function automatic gf_t gf_alog(input int e);
    gf_t r;
    r = 6'd1;
    for (int i = 0; i < e; i++) r = gf_xtime(r);
    return r;
  endfunction

  // a^62 is the inverse for nonzero a
  function automatic gf_t gf_inv(input gf_t a);
    gf_t r;
    gf_t p;
    r = 6'd1;
    p = gf_mul(a, a);
    for (int k = 1; k < 6; k++) begin
      r = gf_mul(r, p);
      p = gf_mul(p, p);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/nbd_ctrl.sv =====
`default_nettype none
module nbd_ctrl #(
  parameter int NS = 22
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  input  nbd_pkg::stat_t      stat,
  output nbd_pkg::cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_SYN, S_BM_INIT, S_BM_MUL, S_BM_RED, S_BM_UPD, S_CH_INIT, S_CHIEN, S_FIN
  } state_t;

  state_t     state_r;
  logic [5:0] cnt_r;
  logic       out_valid_r;
  logic       out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE:    cmd.load = in_valid;
      S_SYN:     cmd.syn_step = 1'b1;
      S_BM_INIT: cmd.bm_init = 1'b1;
      S_BM_MUL:  cmd.bm_mul = 1'b1;
      S_BM_RED:  cmd.bm_red = 1'b1;
      S_BM_UPD:  cmd.bm_upd = 1'b1;
      S_CH_INIT: cmd.ch_init = 1'b1;
      S_CHIEN:   cmd.ch_step = 1'b1;
      S_FIN:     cmd.finish = out_free;
      default:   cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_FIN && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          cnt_r <= '0;
          if (in_valid) state_r <= S_SYN;
        end
        S_SYN: begin
          if (cnt_r == 6'd62) begin
            cnt_r   <= '0;
            state_r <= S_BM_INIT;
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        S_BM_INIT: state_r <= S_BM_MUL;
        S_BM_MUL:  state_r <= S_BM_RED;
        S_BM_RED:  state_r <= S_BM_UPD;
        S_BM_UPD: begin
          if (cnt_r == 6'(NS - 1)) begin
            cnt_r   <= '0;
            state_r <= S_CH_INIT;
          end else begin
            cnt_r   <= cnt_r + 6'd1;
            state_r <= S_BM_MUL;
          end
        end
        S_CH_INIT: begin
          // locator too long: no search needed, decode fails
          if (stat.l_over) state_r <= S_FIN;
          else state_r <= S_CHIEN;
        end
        S_CHIEN: begin
          if (cnt_r == 6'd62) begin
            cnt_r   <= '0;
            state_r <= S_FIN;
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        S_FIN: begin
          if (out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || !out_stall))
    else $error("result written over a pending transfer");
  a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("finished result not presented");
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_SYN && in_stall))
    else $error("accepted word did not start decoding");
`endif

endmodule
`default_nettype wire

// ===== src/nbd_datapath.sv =====
`default_nettype none
module nbd_datapath #(
  parameter int T = 11
) (
  input  wire logic          clk,
  input  nbd_pkg::cmd_t      cmd,
  output nbd_pkg::stat_t     stat,
  input  wire logic [62:0]   in_codeword,
  output logic               out_decode_ok,
  output logic [3:0]         out_error_count,
  output logic [11:0]        out_nac,
  output logic [3:0]         out_duid
);

  localparam int NS = 2 * T;
  localparam int PS = 2 * T + 2;
  localparam int LW = $clog2(PS);

  logic [62:0]        word_r, sh_r, flips_r;
  nbd_pkg::gf_t       syn_r [1:NS];
  nbd_pkg::gf_t       w_r   [0:PS-1];
  nbd_pkg::gf_t       c_r   [0:PS-1];
  nbd_pkg::gf_t       bs_r  [0:PS-1];
  nbd_pkg::gf_t       prod_r[0:PS-1];
  nbd_pkg::gf_t       g_r   [0:T];
  nbd_pkg::gf_t       b_r, binv_r, d_r, coef_r;
  logic [LW-1:0]      l_r, n_r;
  logic [5:0]         j_r, cnt_r;
  nbd_pkg::gf_t       d_sum, v_sum;
  logic               grow;
  logic [5:0]         pos;
  logic [62:0]        fixed;
  logic               ok;

  assign stat.l_over = (7'(l_r) > 7'(T));

  always_comb begin
    d_sum = '0;
    for (int k = 0; k < PS; k++) d_sum = d_sum ^ prod_r[k];
    v_sum = '0;
    for (int i = 0; i <= T; i++) v_sum = v_sum ^ g_r[i];
  end

  assign grow  = ({1'b0, l_r, 1'b0} <= {2'b00, n_r});
  assign pos   = (j_r == 6'd0) ? 6'd0 : 6'd63 - j_r;
  assign ok    = !stat.l_over && (7'(cnt_r) == 7'(l_r));
  assign fixed = word_r ^ flips_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word_r <= in_codeword;
      sh_r   <= in_codeword;
      for (int k = 1; k <= NS; k++) syn_r[k] <= '0;
    end
    // horner over positions 62 down to 0, one lane per syndrome
    if (cmd.syn_step) begin
      sh_r <= {sh_r[61:0], 1'b0};
      for (int k = 1; k <= NS; k++)
        syn_r[k] <= nbd_pkg::gf_mul(syn_r[k], nbd_pkg::gf_alog(k)) ^ {5'd0, sh_r[62]};
    end
    if (cmd.bm_init) begin
      for (int k = 0; k < PS; k++) begin
        w_r[k]  <= (k == 0) ? syn_r[1] : 6'd0;
        c_r[k]  <= (k == 0) ? 6'd1 : 6'd0;
        bs_r[k] <= (k == 1) ? 6'd1 : 6'd0;
      end
      for (int k = 1; k < NS; k++) syn_r[k] <= syn_r[k+1];
      syn_r[NS] <= '0;
      b_r <= 6'd1;
      l_r <= '0;
      n_r <= '0;
    end
    if (cmd.bm_mul) begin
      for (int k = 0; k < PS; k++)
        prod_r[k] <= (LW'(k) <= l_r) ? nbd_pkg::gf_mul(c_r[k], w_r[k]) : 6'd0;
      binv_r <= nbd_pkg::gf_inv(b_r);
    end
    if (cmd.bm_red) begin
      d_r    <= d_sum;
      coef_r <= nbd_pkg::gf_mul(d_sum, binv_r);
    end
    // bs_r holds x^m * B(x)
    if (cmd.bm_upd) begin
      if (d_r != 6'd0 && grow) begin
        bs_r[0] <= '0;
        for (int k = 1; k < PS; k++) bs_r[k] <= c_r[k-1];
        b_r <= d_r;
        l_r <= LW'(n_r + 1'b1 - l_r);
      end else begin
        bs_r[0] <= '0;
        for (int k = 1; k < PS; k++) bs_r[k] <= bs_r[k-1];
      end
      if (d_r != 6'd0)
        for (int k = 0; k < PS; k++) c_r[k] <= c_r[k] ^ nbd_pkg::gf_mul(coef_r, bs_r[k]);
      n_r    <= n_r + 1'b1;
      w_r[0] <= syn_r[1];
      for (int k = 1; k < PS; k++) w_r[k] <= w_r[k-1];
      for (int k = 1; k < NS; k++) syn_r[k] <= syn_r[k+1];
      syn_r[NS] <= '0;
    end
    if (cmd.ch_init) begin
      for (int i = 0; i <= T; i++) g_r[i] <= (LW'(i) <= l_r) ? c_r[i] : 6'd0;
      j_r     <= '0;
      cnt_r   <= '0;
      flips_r <= '0;
    end
    if (cmd.ch_step) begin
      for (int i = 0; i <= T; i++) g_r[i] <= nbd_pkg::gf_mul(g_r[i], nbd_pkg::gf_alog(i));
      j_r <= j_r + 6'd1;
      if (v_sum == 6'd0) begin
        cnt_r       <= cnt_r + 6'd1;
        flips_r[pos] <= 1'b1;
      end
    end
    if (cmd.finish) begin
      out_decode_ok   <= ok;
      out_error_count <= ok ? 4'(cnt_r) : 4'd0;
      for (int i = 0; i < 12; i++) out_nac[11-i] <= ok & fixed[i];
      for (int i = 0; i < 4; i++) out_duid[3-i] <= ok & fixed[12+i];
    end
  end

endmodule
`default_nettype wire

// ===== src/nid_bch_63_16_decoder.sv =====
`default_nettype none
// bch(63,16) decoder over gf(64), x^6+x^5+1, correcting up to CORRECT_CAPABILITY bit errors.
// one word is taken at a time; after the input transfer the decoder runs bit-serial syndrome
// lanes over positions 62 down to 0, a setup step, 2*CORRECT_CAPABILITY berlekamp-massey
// iterations (each a multiply, reduce and update step), a chien search load, the chien search
// at one position a cycle and a final write of the result, after which out_valid rises. when
// the locator is too long the search is skipped and the result is written after the chien
// search load. in_stall stays high while a word is being decoded, so a new word is taken only
// once the current result has been written;
// the result register frees the output side so a stalled result only holds up the final
// write. on failure error_count, nac and duid read 0.
module nid_bch_63_16_decoder #(
  parameter int CORRECT_CAPABILITY = 11
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [62:0] in_codeword,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_decode_ok,
  output logic [3:0]       out_error_count,
  output logic [11:0]      out_nac,
  output logic [3:0]       out_duid
);

  nbd_pkg::cmd_t  cmd;
  nbd_pkg::stat_t stat;

  nbd_ctrl #(.NS(2 * CORRECT_CAPABILITY)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  nbd_datapath #(.T(CORRECT_CAPABILITY)) u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .stat            (stat),
    .in_codeword     (in_codeword),
    .out_decode_ok   (out_decode_ok),
    .out_error_count (out_error_count),
    .out_nac         (out_nac),
    .out_duid        (out_duid)
  );

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

  localparam int T_CAP = 11;
  localparam int N_RANDOM = 880;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic        ok;
    logic [3:0]  nfixed;
    logic [11:0] nac;
    logic [3:0]  duid;
  } decoded_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [62:0] in_codeword = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_decode_ok;
  logic [3:0] out_error_count;
  logic [11:0] out_nac;
  logic [3:0] out_duid;

  decoded_t expected_q[$];
  int n_errors = 0;
  int idle_cycles = 0;
  logic [5:0] exp_tab[0:62];
  logic [5:0] log_tab[0:63];
  logic [62:0] gen_poly;
  int stall_mode = 0;
  int burst_left = 0;

  nid_bch_63_16_decoder dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_codeword(in_codeword),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_decode_ok(out_decode_ok), .out_error_count(out_error_count),
    .out_nac(out_nac), .out_duid(out_duid)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [5:0] fmul(logic [5:0] a, logic [5:0] b);
    if (a == 0 || b == 0) return 6'd0;
    return exp_tab[(int'(log_tab[a]) + int'(log_tab[b])) % 63];
  endfunction

  function automatic logic [5:0] fdiv(logic [5:0] a, logic [5:0] b);
    if (a == 0 || b == 0) return 6'd0;
    return exp_tab[(int'(log_tab[a]) + 63 - int'(log_tab[b])) % 63];
  endfunction

  function automatic decoded_t predict_word(logic [62:0] word);
    logic [5:0] syn[0:22];
    logic [5:0] c[0:23];
    logic [5:0] bb[0:23];
    logic [5:0] tmp[0:23];
    logic [5:0] d, bcoef, coef, v;
    logic [62:0] flips;
    int lcur, m, cnt;
    logic any_syn, ok;
    decoded_t r;
    any_syn = 1'b0;
    ok = 1'b1;
    cnt = 0;
    for (int i = 1; i <= 2 * T_CAP; i++) begin
      syn[i] = 6'd0;
      for (int j = 0; j < 63; j++)
        if (word[j]) syn[i] ^= exp_tab[(i * j) % 63];
      if (syn[i] != 0) any_syn = 1'b1;
    end
    if (any_syn) begin
      for (int i = 0; i < 24; i++) begin
        c[i] = 6'd0;
        bb[i] = 6'd0;
      end
      c[0] = 6'd1;
      bb[0] = 6'd1;
      lcur = 0;
      m = 1;
      bcoef = 6'd1;
      for (int n = 0; n < 2 * T_CAP; n++) begin
        d = syn[n + 1];
        for (int i = 1; i <= lcur && i <= n; i++) d ^= fmul(c[i], syn[n + 1 - i]);
        if (d == 0) m++;
        else begin
          coef = fdiv(d, bcoef);
          tmp = c;
          for (int i = 0; i + m < 24; i++) c[i + m] ^= fmul(coef, bb[i]);
          if (2 * lcur <= n) begin
            lcur = n + 1 - lcur;
            bb = tmp;
            bcoef = d;
            m = 1;
          end else m++;
        end
      end
      if (lcur > T_CAP) ok = 1'b0;
      else begin
        flips = '0;
        for (int j = 0; j < 63; j++) begin
          v = 6'd0;
          for (int i = 0; i <= lcur; i++) v ^= fmul(c[i], exp_tab[(i * j) % 63]);
          if (v == 0) begin
            cnt++;
            flips[(63 - j) % 63] = 1'b1;
          end
        end
        if (cnt != lcur) ok = 1'b0;
        else word ^= flips;
      end
    end
    r = '0;
    if (ok) begin
      r.ok = 1'b1;
      r.nfixed = cnt[3:0];
      for (int i = 0; i < 12; i++) r.nac[11 - i] = word[i];
      for (int i = 0; i < 4; i++) r.duid[3 - i] = word[12 + i];
    end
    return r;
  endfunction

  // minimal polynomial of alpha^k, coefficients as bits
  function automatic logic [62:0] min_poly(int k);
    logic [5:0] p[0:7];
    logic [62:0] r;
    logic [5:0] root;
    int deg, e;
    for (int i = 0; i < 8; i++) p[i] = 6'd0;
    p[0] = 6'd1;
    deg = 0;
    e = k % 63;
    do begin
      root = exp_tab[e];
      for (int i = deg + 1; i > 0; i--) p[i] = p[i - 1] ^ fmul(p[i], root);
      p[0] = fmul(p[0], root);
      deg++;
      e = (e * 2) % 63;
    end while (e != k % 63);
    r = '0;
    for (int i = 0; i <= deg; i++) r[i] = p[i][0];
    return r;
  endfunction

  function automatic logic [62:0] pmul(logic [62:0] a, logic [62:0] b);
    logic [62:0] r;
    r = '0;
    for (int i = 0; i < 63; i++) if (b[i]) r ^= a << i;
    return r;
  endfunction

  function automatic logic [62:0] encode(logic [15:0] msg);
    return pmul(gen_poly, {47'd0, msg});
  endfunction

  function automatic logic [62:0] add_errors(logic [62:0] w, int n);
    logic [62:0] mask;
    int pos;
    mask = '0;
    while ($countones(mask) < n) begin
      pos = $urandom_range(62, 0);
      mask[pos] = 1'b1;
    end
    return w ^ mask;
  endfunction

  // valid stays high through a burst; a gap follows the last word of each burst
  task automatic send_word(logic [62:0] w);
    int gap;
    in_valid <= 1'b1;
    in_codeword <= w;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(predict_word(w));
    if (burst_left == 0) begin
      burst_left = $urandom_range(8, 1);
      gap = $urandom_range(12, 1);
    end else begin
      burst_left--;
      gap = 0;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_codeword <= 63'({$urandom, $urandom});
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic test_extremes();
    send_word('0);
    send_word({63{1'b1}});
    send_word(63'h5555_5555_5555_5555);
    send_word(63'h2AAA_AAAA_AAAA_AAAA);
    send_word(63'd1);
    send_word(63'd1 << 62);
  endtask

  task automatic test_error_weights();
    for (int n = 0; n <= 13; n++) send_word(add_errors(encode(16'($urandom)), n));
    send_word(encode(16'hFFFF));
    send_word(add_errors(encode(16'hA5C3), 11));
  endtask

  task automatic test_random();
    int kind;
    for (int k = 0; k < N_RANDOM; k++) begin
      kind = $urandom_range(9, 0);
      stall_mode = (k / 150) % 3;
      if (kind < 7) send_word(add_errors(encode(16'($urandom)), $urandom_range(T_CAP, 0)));
      else if (kind < 9)
        send_word(add_errors(encode(16'($urandom)), $urandom_range(20, T_CAP + 1)));
      else send_word(63'({$urandom, $urandom}));
    end
  endtask

  // stall pattern changes with the phase of the run; mode 0 never stalls
  always @(posedge clk) begin
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(3, 0) == 0);
      default: out_stall <= ($urandom_range(9, 0) < 7);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected");
        n_errors++;
      end else begin
        decoded_t e;
        e = expected_q.pop_front();
        if (out_decode_ok !== e.ok) begin
          $error("decode_ok exp %0d got %0d", e.ok, out_decode_ok);
          n_errors++;
        end
        if (out_error_count !== e.nfixed) begin
          $error("error_count exp %0d got %0d", e.nfixed, out_error_count);
          n_errors++;
        end
        if (out_nac !== e.nac) begin
          $error("nac exp %h got %h", e.nac, out_nac);
          n_errors++;
        end
        if (out_duid !== e.duid) begin
          $error("duid exp %h got %h", e.duid, out_duid);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [5:0] r;
    r = 6'd1;
    for (int i = 0; i < 63; i++) begin
      exp_tab[i] = r;
      log_tab[r] = 6'(i);
      r = {r[4:0], 1'b0} ^ (r[5] ? 6'h21 : 6'h00);
    end
    log_tab[0] = 6'd0;
    gen_poly = 63'd1;
    // distinct cyclotomic cosets among 1..21
    gen_poly = pmul(gen_poly, min_poly(1));
    gen_poly = pmul(gen_poly, min_poly(3));
    gen_poly = pmul(gen_poly, min_poly(5));
    gen_poly = pmul(gen_poly, min_poly(7));
    gen_poly = pmul(gen_poly, min_poly(9));
    gen_poly = pmul(gen_poly, min_poly(11));
    gen_poly = pmul(gen_poly, min_poly(13));
    gen_poly = pmul(gen_poly, min_poly(15));
    gen_poly = pmul(gen_poly, min_poly(21));
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    stall_mode = 1;
    test_error_weights();
    test_random();
    in_valid <= 1'b0;
    stall_mode = 1;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (n_errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
src/nbd_pkg.sv
src/nbd_ctrl.sv
src/nbd_datapath.sv
src/nid_bch_63_16_decoder.sv
tb/testbench.sv
